FILE: rtl/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } hcbp_cmd_type;

   // Width of the block size register and of the byte position within a block.
   localparam int unsigned SIZE_W = 13;
   localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 13'd4096;

   // Code entry layout.
   localparam int unsigned ENTRY_W = 16;
   localparam logic [3:0] MAX_LEN = 4'd12;

   // One result item.
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        block_end;
      logic        done_res;
      logic [15:0] pad_bits;
      logic [31:0] block_count;
   } hcbp_result_type;

   // Results produced by the stream stage in one cycle (zero to two).
   typedef struct packed {
      logic [1:0]      count;
      hcbp_result_type first;
      hcbp_result_type second;
   } hcbp_push_type;

endpackage

`default_nettype wire

FILE: rtl/hcbp_if.sv
`default_nettype none

// Request channel: one command with its operands.
interface hcbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  table_index;
   logic [15:0] table_entry;
   logic [7:0]  data_byte;

   modport source (output valid, command, table_index, table_entry, data_byte,
                   input ready);
   modport sink   (input valid, command, table_index, table_entry, data_byte,
                   output ready);
endinterface

// Result channel: one output byte or the flush summary.
interface hcbp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_valid;
   logic        block_end;
   logic        done_res;
   logic [15:0] pad_bits;
   logic [31:0] block_count;

   modport source (output valid, out_byte, byte_valid, block_end, done_res, pad_bits,
                   block_count, input ready);
   modport sink   (input valid, out_byte, byte_valid, block_end, done_res, pad_bits,
                   block_count, output ready);
endinterface

// Configuration write channel: the block size register.
interface hcbp_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] block_size;

   modport source (output valid, block_size, input ready);
   modport sink   (input valid, block_size, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcbp_ram.sv
`default_nettype none

module hcbp_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/hcbp_stream.sv
`default_nettype none

module hcbp_stream #(
   parameter int unsigned MAX_BLOCK = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            issue_valid,
   input  wire logic                            issue_flush,
   output logic                                 issue_ready,
   input  wire logic [hcbp_pkg::ENTRY_W-1:0]    entry,
   input  wire logic [hcbp_pkg::SIZE_W-1:0]     block_size,
   input  wire logic [1:0]                      free_slots,
   output hcbp_pkg::hcbp_push_type              push
);

   import hcbp_pkg::*;

   // Stage holding the request whose table entry is on the RAM output.
   logic s1_valid_ff, s1_valid_in;
   logic s1_flush_ff, s1_flush_in;

   // Stream state.
   logic [6:0]        pending_ff, pending_in;
   logic [2:0]        count_ff, count_in;
   logic [SIZE_W-1:0] pos_ff, pos_in;
   logic [31:0]       blocks_ff, blocks_in;

   logic [SIZE_W-1:0] size;
   logic [3:0]        len;
   logic [11:0]       code;
   logic [18:0]       acc;
   logic [4:0]        total;
   logic [1:0]        needed;
   logic              fire;
   logic [SIZE_W-1:0] pos_a, pos_b, pos_c, pos_clamp;
   logic              end_a, end_b;
   logic [31:0]       blocks_a;
   logic              nonempty;
   hcbp_result_type   res_a, res_b;

   // Effective block size: zero acts as one, large values clamp.
   always_comb begin
      size = block_size;
      if (block_size == '0) begin
         size = SIZE_W'(1);
      end else if (32'(block_size) > MAX_BLOCK) begin
         size = SIZE_W'(MAX_BLOCK);
      end
   end

   // Code extraction and bit accumulation.
   always_comb begin
      len   = (entry[3:0] > MAX_LEN) ? MAX_LEN : entry[3:0];
      code  = entry[15:4] & ~(12'hFFF << len);
      acc   = ({12'b0, pending_ff} << len) | {7'b0, code};
      total = {2'b0, count_ff} + {1'b0, len};
   end

   // Byte position and block tracking for up to two completed bytes.
   always_comb begin
      pos_a    = pos_ff + SIZE_W'(1);
      end_a    = (pos_a >= size);
      pos_b    = end_a ? '0 : pos_a;
      blocks_a = end_a ? blocks_ff + 32'd1 : blocks_ff;
      pos_c    = pos_b + SIZE_W'(1);
      end_b    = (pos_c >= size);
      nonempty = (pos_ff != '0) || (count_ff != '0);
      pos_clamp = (pos_ff < size) ? pos_ff : size;
   end

   // Result items and the number of queue slots they need.
   always_comb begin
      res_a = '0;
      res_b = '0;
      needed = 2'd0;
      if (s1_flush_ff) begin
         needed = 2'd1;
         res_a.done_res = 1'b1;
         if (nonempty) begin
            res_a.out_byte    = 8'({1'b0, pending_ff} << (4'd8 - {1'b0, count_ff}));
            res_a.byte_valid  = (count_ff != '0);
            res_a.pad_bits    = {(size - pos_clamp), 3'b0} - {13'b0, count_ff};
            res_a.block_count = blocks_ff + 32'd1;
         end else begin
            res_a.block_count = blocks_ff;
         end
      end else begin
         if (total >= 5'd16) begin
            needed = 2'd2;
         end else if (total >= 5'd8) begin
            needed = 2'd1;
         end
         res_a.out_byte   = 8'(acc >> (total - 5'd8));
         res_a.byte_valid = 1'b1;
         res_a.block_end  = end_a;
         res_b.out_byte   = 8'(acc >> (total - 5'd16));
         res_b.byte_valid = 1'b1;
         res_b.block_end  = end_b;
      end
   end

   assign fire        = s1_valid_ff && (needed <= free_slots);
   assign issue_ready = !s1_valid_ff || fire;

   always_comb begin
      push.count  = fire ? needed : 2'd0;
      push.first  = res_a;
      push.second = res_b;
   end

   // Next state of the stage and of the stream.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_flush_in = s1_flush_ff;
      pending_in  = pending_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      blocks_in   = blocks_ff;
      if (issue_ready) begin
         s1_valid_in = issue_valid;
         s1_flush_in = issue_flush;
      end
      if (fire) begin
         if (s1_flush_ff) begin
            pending_in = '0;
            count_in   = '0;
            pos_in     = '0;
            blocks_in  = '0;
         end else begin
            count_in   = total[2:0];
            pending_in = 7'(acc) & ~(7'h7F << total[2:0]);
            case (needed)
               2'd1: begin
                  pos_in    = pos_b;
                  blocks_in = blocks_a;
               end
               2'd2: begin
                  pos_in    = end_b ? '0 : pos_c;
                  blocks_in = end_b ? blocks_a + 32'd1 : blocks_a;
               end
               default: begin
                  pos_in    = pos_ff;
                  blocks_in = blocks_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_flush_ff <= 1'b0;
         pending_ff  <= '0;
         count_ff    <= '0;
         pos_ff      <= '0;
         blocks_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_flush_ff <= s1_flush_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         pos_ff      <= pos_in;
         blocks_ff   <= blocks_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hcbp_out_queue.sv
`default_nettype none

module hcbp_out_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire hcbp_pkg::hcbp_push_type push,
   output logic [1:0]                   free_slots,
   hcbp_rsp_if.source                   rsp
);

   import hcbp_pkg::*;

   hcbp_result_type head_ff, head_in;
   hcbp_result_type tail_ff, tail_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      cnt_left;
   logic            pop;

   assign pop        = rsp.valid && rsp.ready;
   assign free_slots = 2'd2 - cnt_ff + {1'b0, pop};

   // Pop first, then append up to two new results behind what is left.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      cnt_left = cnt_ff;
      if (pop) begin
         head_in  = tail_ff;
         cnt_left = cnt_ff - 2'd1;
      end
      if (push.count != 2'd0) begin
         if (cnt_left == 2'd0) begin
            head_in = push.first;
         end else begin
            tail_in = push.first;
         end
      end
      if (push.count == 2'd2) begin
         tail_in = push.second;
      end
      cnt_in = cnt_left + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.out_byte    = head_ff.out_byte;
   assign rsp.byte_valid  = head_ff.byte_valid;
   assign rsp.block_end   = head_ff.block_end;
   assign rsp.done_res    = head_ff.done_res;
   assign rsp.pad_bits    = head_ff.pad_bits;
   assign rsp.block_count = head_ff.block_count;

endmodule

`default_nettype wire

FILE: rtl/huffman_code_bit_packer.sv
`default_nettype none

// Channel   Direction  Payload
// req       in         command, table_index, table_entry, data_byte
// rsp       out        out_byte, byte_valid, block_end, done_res, pad_bits, block_count
// csr       in         block_size (always ready)
//
// A request is taken every cycle while the result port keeps up. That port moves one
// result per cycle, so a request that completes two bytes waits until the two-entry
// result queue has room for both. An accepted request is registered in the stream
// stage while the code table RAM is read, and the stage uses the registered entry in
// the next cycle; its results are then registered in the queue that feeds rsp.
// Reset clears the stream state and result queue; the code table is not cleared.
// A stalled result port backs up into the request channel once the queue lacks room.

module huffman_code_bit_packer #(
   parameter int unsigned TABLE_ENTRIES = 256,
   parameter int unsigned MAX_BLOCK     = 4096
) (
   input wire logic   clock,
   input wire logic   reset,
   hcbp_req_if.sink   req,
   hcbp_rsp_if.source rsp,
   hcbp_csr_if.sink   csr
);

   import hcbp_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);

   logic [SIZE_W-1:0]  block_size_ff;
   logic               accept;
   logic               do_load, do_encode, do_flush;
   logic               issue_ready;
   logic [ENTRY_W-1:0] entry;
   logic [1:0]         free_slots;
   hcbp_push_type      push;

   // Block size register.
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RESET;
      end else if (csr.valid) begin
         block_size_ff <= csr.block_size;
      end
   end

   // Command decode at acceptance.
   assign req.ready = issue_ready;
   assign accept    = req.valid && req.ready;
   always_comb begin
      do_load   = 1'b0;
      do_encode = 1'b0;
      do_flush  = 1'b0;
      unique case (hcbp_cmd_type'(req.command))
         CMD_LOAD:   do_load   = accept;
         CMD_ENCODE: do_encode = accept;
         CMD_FLUSH:  do_flush  = accept;
         default:    do_load   = 1'b0;
      endcase
   end

   // Code table.
   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (req.table_index[ADDR_W-1:0]),
      .wr_data (req.table_entry),
      .rd_en   (do_encode),
      .rd_addr (req.data_byte[ADDR_W-1:0]),
      .rd_data (entry)
   );

   // Bit packing and block accounting.
   hcbp_stream #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_stream (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (do_encode || do_flush),
      .issue_flush (do_flush),
      .issue_ready (issue_ready),
      .entry       (entry),
      .block_size  (block_size_ff),
      .free_slots  (free_slots),
      .push        (push)
   );

   // Result queue toward the response channel.
   hcbp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .free_slots (free_slots),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

FILE: tb/sv/hcbp_stream_check.sv
`default_nettype none

// Watches the request, result and register channels of the bit packer, keeps its own
// copy of the code table and stream state, and checks every result byte in order.
module hcbp_stream_check
   import hcbp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   hcbp_req_if       req,
   hcbp_rsp_if       rsp,
   hcbp_csr_if       csr,
   output int        fail_count,
   output int        outstanding
);

   // Shadow copy of the code table and the bit stream.
   logic [ENTRY_W-1:0] code_mem [256];
   logic [6:0]         held_bits;
   logic [2:0]         held_count;
   int unsigned        bytes_in_block;
   logic [31:0]        full_blocks;
   logic [SIZE_W-1:0]  size_reg;

   // Result bytes still owed by the block, oldest first.
   hcbp_result_type    bytes_due [$];
   int                 mismatches = 0;

   // Block size as the stream uses it: zero acts as one, large values clamp.
   function automatic int unsigned active_size();
      int unsigned size;
      size = size_reg;
      if (size == 0) size = 1;
      if (size > 4096) size = 4096;
      return size;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Appends the code of one symbol and queues every byte that it completes.
   task automatic pack_symbol(input logic [7:0] symbol);
      int unsigned     entry;
      int unsigned     len;
      int unsigned     code;
      int unsigned     acc;
      int unsigned     total;
      int unsigned     size;
      hcbp_result_type res;
      size  = active_size();
      entry = code_mem[symbol];
      len   = entry & 32'hF;
      if (len > MAX_LEN) len = MAX_LEN;
      code  = (entry >> 4) & ((1 << len) - 1);
      acc   = (int'(held_bits) << len) | code;
      total = held_count + len;
      while (total >= 8) begin
         total -= 8;
         res = '0;
         res.out_byte   = 8'(acc >> total);
         res.byte_valid = 1'b1;
         bytes_in_block++;
         if (bytes_in_block >= size) begin
            res.block_end  = 1'b1;
            bytes_in_block = 0;
            full_blocks++;
         end
         bytes_due.push_back(res);
      end
      held_count = 3'(total);
      held_bits  = 7'(acc & ((1 << total) - 1));
   endtask

   // Queues the closing summary of the stream and clears the stream state.
   task automatic flush_stream();
      int unsigned     size;
      int unsigned     pos;
      hcbp_result_type res;
      size = active_size();
      res  = '0;
      res.done_res = 1'b1;
      if (bytes_in_block != 0 || held_count != 0) begin
         pos = (bytes_in_block < size) ? bytes_in_block : size;
         res.pad_bits = 16'(8 * (size - pos) - held_count);
         if (held_count != 0) begin
            res.out_byte   = 8'(int'(held_bits) << (8 - held_count));
            res.byte_valid = 1'b1;
         end
         res.block_count = full_blocks + 1;
      end else begin
         res.block_count = full_blocks;
      end
      bytes_due.push_back(res);
      held_bits      = '0;
      held_count     = '0;
      bytes_in_block = 0;
      full_blocks    = '0;
   endtask

   // Compares one accepted result with the oldest byte owed.
   task automatic check_result();
      hcbp_result_type want;
      if (bytes_due.size() == 0) begin
         report_mismatch("unexpected result, out_byte", rsp.out_byte, '0);
         return;
      end
      want = bytes_due.pop_front();
      if (rsp.out_byte !== want.out_byte)
         report_mismatch("out_byte", rsp.out_byte, want.out_byte);
      if (rsp.byte_valid !== want.byte_valid)
         report_mismatch("byte_valid", rsp.byte_valid, want.byte_valid);
      if (rsp.block_end !== want.block_end)
         report_mismatch("block_end", rsp.block_end, want.block_end);
      if (rsp.done_res !== want.done_res)
         report_mismatch("done_res", rsp.done_res, want.done_res);
      if (rsp.pad_bits !== want.pad_bits)
         report_mismatch("pad_bits", rsp.pad_bits, want.pad_bits);
      if (rsp.block_count !== want.block_count)
         report_mismatch("block_count", rsp.block_count, want.block_count);
   endtask

   // Everything is sampled at the rising edge; the counts go out through nonblocking assignments.
   always @(posedge clock) begin
      if (reset) begin
         held_bits      = '0;
         held_count     = '0;
         bytes_in_block = 0;
         full_blocks    = '0;
         size_reg       = BLOCK_SIZE_RESET;
         bytes_due.delete();
      end else begin
         if (csr.valid && csr.ready) size_reg = csr.block_size;
         if (req.valid && req.ready) begin
            case (hcbp_cmd_type'(req.command))
               CMD_LOAD:   code_mem[req.table_index] = req.table_entry;
               CMD_ENCODE: pack_symbol(req.data_byte);
               CMD_FLUSH:  flush_stream();
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) check_result();
      end
      outstanding <= bytes_due.size();
      fail_count  <= mismatches;
   end

endmodule

`default_nettype wire

FILE: tb/sv/huffman_code_bit_packer_tb.sv
`default_nettype none

// Drives requests, result back-pressure and block size writes into the bit packer;
// the stream checker beside it does all prediction and comparison.
module huffman_code_bit_packer_tb;
   import hcbp_pkg::*;

   logic clock = 1'b0;
   logic reset;

   hcbp_req_if req_ch ();
   hcbp_rsp_if rsp_ch ();
   hcbp_csr_if csr_ch ();

   int fail_count;
   int outstanding;

   // Stimulus controls; quiet and the hold counts are shared with the result-side process.
   bit quiet       = 1'b0;
   bit sender_gaps = 1'b1;
   int holds_asked  = 0;
   int holds_served = 0;

   // Table entries written so far; only these are ever looked up.
   bit         loaded [256];
   logic [7:0] loaded_list [$];

   huffman_code_bit_packer uut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   hcbp_stream_check stream_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result-side back-pressure: random short stalls, one long hold on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_ch.ready = 1'b0;
            repeat (80) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   function automatic logic [7:0] pick_loaded();
      if (loaded_list.size() == 0) return 8'd0;
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   // Offers one request, with an optional idle burst first, and waits for acceptance.
   task automatic send_request(input hcbp_cmd_type cmd, input logic [7:0] index,
                               input logic [15:0] entry, input logic [7:0] symbol);
      int gap;
      if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.command     = cmd;
      req_ch.table_index = index;
      req_ch.table_entry = entry;
      req_ch.data_byte   = symbol;
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (cmd == CMD_LOAD && !loaded[index]) begin
         loaded[index] = 1'b1;
         loaded_list.push_back(index);
      end
   endtask

   task automatic load_code(input logic [7:0] index, input logic [15:0] entry);
      send_request(CMD_LOAD, index, entry, pick_loaded());
   endtask

   task automatic encode_symbol(input logic [7:0] symbol);
      send_request(CMD_ENCODE, 8'($urandom()), 16'($urandom()), symbol);
   endtask

   task automatic flush_packer();
      send_request(CMD_FLUSH, 8'($urandom()), 16'($urandom()), pick_loaded());
   endtask

   // One random request; mostly encodes of loaded symbols.
   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         load_code(8'($urandom()), 16'($urandom()));
      else if (pick < 90)
         encode_symbol(pick_loaded());
      else if (pick < 97)
         flush_packer();
      else
         send_request(CMD_NONE, 8'($urandom()), 16'($urandom()), pick_loaded());
   endtask

   // Waits until every owed result has arrived, plus the pipeline latency.
   task automatic drain_outputs();
      @(negedge clock);
      req_ch.valid = 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes the block size register while the block is idle.
   task automatic write_block_size(input logic [12:0] size);
      drain_outputs();
      @(negedge clock);
      csr_ch.block_size = size;
      csr_ch.valid      = 1'b1;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   logic [12:0] phase_sizes [8];

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_LOAD;
      req_ch.table_index = '0;
      req_ch.table_entry = '0;
      req_ch.data_byte   = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.block_size  = BLOCK_SIZE_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Table entries covering zero, full, saturated and stray-bit codes.
      load_code(8'd0,   16'h0000);
      load_code(8'd255, 16'hFFFF);
      load_code(8'd1,   16'hABCC);
      load_code(8'd2,   16'hFFF1);
      load_code(8'd3,   16'h05A8);
      load_code(8'd4,   16'h0007);
      load_code(8'd5,   16'h123D);

      // Flush of an empty stream, then codes at the reset block size.
      flush_packer();
      encode_symbol(8'd0);
      encode_symbol(8'd255);
      encode_symbol(8'd1);
      encode_symbol(8'd2);
      encode_symbol(8'd5);
      encode_symbol(8'd4);
      send_request(CMD_NONE, 8'hFF, 16'hFFFF, 8'd255);
      flush_packer();

      // One-byte blocks: every byte ends a block.
      write_block_size(13'd1);
      encode_symbol(8'd3);
      encode_symbol(8'd1);
      encode_symbol(8'd1);
      flush_packer();

      // Shrink the block below the current position before flushing.
      write_block_size(13'd4096);
      encode_symbol(8'd3);
      encode_symbol(8'd3);
      encode_symbol(8'd3);
      encode_symbol(8'd2);
      write_block_size(13'd2);
      flush_packer();

      // Random phases, each at its own block size.
      phase_sizes = '{13'd2, 13'd8191, 13'd3, 13'd0, 13'($urandom_range(4, 40)),
                      13'd1, 13'd5, 13'd7};
      for (int phase = 0; phase < 8; phase++) begin
         write_block_size(phase_sizes[phase]);
         if (phase == 2) begin
            // Long result stall while requests keep coming.
            holds_asked++;
            sender_gaps = 1'b0;
            repeat (40) encode_symbol(pick_loaded());
            sender_gaps = 1'b1;
         end
         if (phase == 7) quiet = 1'b1;
         repeat (40) random_request();
         if ($urandom_range(0, 3) != 0) flush_packer();
      end
      flush_packer();
      drain_outputs();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/hcbp_pkg.sv
rtl/hcbp_if.sv
rtl/hcbp_ram.sv
rtl/hcbp_stream.sv
rtl/hcbp_out_queue.sv
rtl/huffman_code_bit_packer.sv
tb/sv/hcbp_stream_check.sv
tb/sv/huffman_code_bit_packer_tb.sv
